/* src/dpcm_pkg.sv */
// Shared types and constants for the DPCM delta encoder.
package dpcm_pkg;

    localparam int LEVEL_W = 6;
    localparam int COUNT_W = 3;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [WORD_W-1:0]  word_t;

    localparam level_t LEVEL_MID  = level_t'(32);
    localparam level_t LEVEL_MAX  = level_t'(63);
    localparam level_t LEVEL_MIN  = level_t'(0);
    localparam count_t COUNT_LAST = count_t'(7);
    localparam int     SHIFT_16   = 10;
    localparam int     SHIFT_8    = 2;

    // Everything the step logic hands back to the sequencing registers.
    typedef struct packed {
        level_t level;
        byte_t  pack;
        count_t count;
        logic   emit;
        byte_t  out_byte;
    } step_result_t;

endpackage

/* src/dpcm_delta_encoder.sv */
// Top level of the DPCM delta encoder: input register, state and result register.
//
// The encoder takes one sample per clock cycle unless the input is stalled, and turns each
// into one delta bit against a 6-bit tracked level; every eighth sample completes a byte,
// which reaches the output through the input register and then the result register. One
// input register and one result register frame a single pass of compare, step and pack
// logic, so the level state closes its loop within that pass. A stalled result byte holds
// the output register; samples keep being taken as long as they do not complete a new byte,
// and the input is stalled only while a completed byte waits for a full output register.
module dpcm_delta_encoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_write_en,
    input  logic            cfg_write_data,
    input  logic            sample_valid,
    output logic            sample_stall,
    input  dpcm_pkg::word_t sample_word,
    input  logic            pad_sample,
    input  logic            start_of_sample,
    output logic            byte_valid,
    input  logic            byte_stall,
    output dpcm_pkg::byte_t dpcm_byte
);
    import dpcm_pkg::*;

    logic         mode_reg;
    logic         s1_valid_reg;
    word_t        s1_word_reg;
    logic         s1_pad_reg;
    logic         s1_start_reg;
    level_t       level_reg;
    byte_t        pack_reg;
    count_t       count_reg;
    logic         byte_valid_reg;
    logic         byte_valid_next;
    byte_t        byte_reg;
    level_t       sample_level;
    step_result_t step;
    logic         s1_advance;
    logic         s1_fire;

    dpcm_reduce u_reduce (
        .sample_word     (s1_word_reg),
        .pad_sample      (s1_pad_reg),
        .sample_is_16bit (mode_reg),
        .sample_level    (sample_level)
    );

    dpcm_step u_step (
        .level        (level_reg),
        .pack         (pack_reg),
        .count        (count_reg),
        .start        (s1_start_reg),
        .sample_level (sample_level),
        .result       (step)
    );

    // The held sample moves on unless it completes a byte that has nowhere to go.
    always_comb
    begin
        s1_advance      = !s1_valid_reg || !(step.emit && byte_valid_reg && byte_stall);
        s1_fire         = s1_valid_reg && s1_advance;
        sample_stall    = !s1_advance;
        byte_valid_next = (s1_fire && step.emit) || (byte_valid_reg && byte_stall);
    end

    // Control and tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            level_reg      <= LEVEL_MID;
            pack_reg       <= '0;
            count_reg      <= '0;
            byte_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (s1_advance)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (s1_fire)
            begin
                level_reg <= step.level;
                pack_reg  <= step.pack;
                count_reg <= step.count;
            end
            byte_valid_reg <= byte_valid_next;
        end
    end

    // Payload registers for the input stage and the result byte.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            s1_word_reg  <= sample_word;
            s1_pad_reg   <= pad_sample;
            s1_start_reg <= start_of_sample;
        end
        if (s1_fire && step.emit)
        begin
            byte_reg <= step.out_byte;
        end
    end

    assign byte_valid = byte_valid_reg;
    assign dpcm_byte  = byte_reg;

    // A completed byte never lands on a result that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && step.emit |-> !byte_valid_reg || !byte_stall)
        else $error("result byte overwritten while stalled");

    // Bits not yet filled in the packing register stay clear.
    a_pack_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pack_reg & (8'hFF >> count_reg)) == 8'h00)
        else $error("packing register holds stray bits");

    // Without a restart the level moves by at most one step per sample.
    a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && !s1_start_reg |=>
            (level_reg == $past(level_reg)) ||
            (level_reg == $past(level_reg) + level_t'(1)) ||
            (level_reg == $past(level_reg) - level_t'(1)))
        else $error("tracked level jumped");

    // The input is held back only while the stage holds a sample.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> s1_valid_reg && byte_valid_reg && byte_stall)
        else $error("input stalled without cause");

endmodule

/* src/dpcm_reduce.sv */
// Reduction of a raw PCM sample to the 6-bit compare value.
module dpcm_reduce (
    input  dpcm_pkg::word_t  sample_word,
    input  logic             pad_sample,
    input  logic             sample_is_16bit,
    output dpcm_pkg::level_t sample_level
);
    import dpcm_pkg::*;

    // Pad items compare against the midpoint; otherwise keep bits 15:10 (16-bit mode) or 7:2 (8-bit mode).
    always_comb
    begin
        priority if (pad_sample)
        begin
            sample_level = LEVEL_MID;
        end
        else if (sample_is_16bit)
        begin
            sample_level = sample_word[SHIFT_16 +: LEVEL_W];
        end
        else
        begin
            sample_level = sample_word[SHIFT_8 +: LEVEL_W];
        end
    end

endmodule

/* src/dpcm_step.sv */
// Level tracking and bit packing for one sample.
module dpcm_step (
    input  dpcm_pkg::level_t       level,
    input  dpcm_pkg::byte_t        pack,
    input  dpcm_pkg::count_t       count,
    input  logic                   start,
    input  dpcm_pkg::level_t       sample_level,
    output dpcm_pkg::step_result_t result
);
    import dpcm_pkg::*;

    level_t cur_level;
    byte_t  cur_pack;
    count_t cur_count;
    logic   up;
    level_t new_level;
    byte_t  shifted;

    // A start item restarts tracking and drops any partial byte.
    always_comb
    begin
        cur_level = start ? LEVEL_MID : level;
        cur_pack  = start ? '0 : pack;
        cur_count = start ? '0 : count;
    end

    // Compare the sample with the level; a tie steps up except at the rails.
    always_comb
    begin
        priority if (cur_level > sample_level)
        begin
            up        = 1'b0;
            new_level = cur_level - level_t'(1);
        end
        else if (cur_level < sample_level)
        begin
            up        = 1'b1;
            new_level = cur_level + level_t'(1);
        end
        else if (cur_level == LEVEL_MAX)
        begin
            up        = 1'b1;
            new_level = cur_level;
        end
        else if (cur_level == LEVEL_MIN)
        begin
            up        = 1'b0;
            new_level = cur_level;
        end
        else
        begin
            up        = 1'b1;
            new_level = cur_level + level_t'(1);
        end
    end

    // Shift the new bit in at the top so the earliest bit lands in bit 0.
    always_comb
    begin
        shifted         = {up, cur_pack[BYTE_W-1:1]};
        result.level    = new_level;
        result.count    = cur_count + count_t'(1);
        result.emit     = (cur_count == COUNT_LAST);
        result.out_byte = shifted;
        result.pack     = result.emit ? '0 : shifted;
    end

endmodule

/* verif/dpcm_delta_encoder_tb.sv */
// Self-checking testbench for the DPCM delta encoder: directed table, then random segments.
module dpcm_delta_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dpcm_pkg::*;

    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RAND_ITEMS   = 660;
    localparam int QUIET_ITEMS  = 100;
    localparam int DIR_N        = 27;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;
    typedef enum int {SEG_NOISE, SEG_SATURATE, SEG_TRACK, SEG_HOLD} seg_kind_t;

    // One row of the directed table; known_byte is used only where has_known is set.
    typedef struct packed {
        row_kind_t kind;
        word_t     word;
        logic      pad;
        logic      start;
        logic      cfg_val;
        logic      has_known;
        byte_t     known_byte;
    } dir_row_t;

    logic  clk             = 1'b0;
    logic  rst_n           = 1'b0;
    logic  cfg_write_en    = 1'b0;
    logic  cfg_write_data  = 1'b0;
    logic  sample_valid    = 1'b0;
    logic  sample_stall;
    word_t sample_word     = '0;
    logic  pad_sample      = 1'b0;
    logic  start_of_sample = 1'b0;
    logic  byte_valid;
    logic  byte_stall      = 1'b0;
    byte_t dpcm_byte;

    // Encoder state as the testbench tracks it.
    logic   sixteen_bit = 1'b0;
    level_t track_lvl   = LEVEL_MID;
    byte_t  pack_bits   = '0;
    count_t pack_count  = '0;

    byte_t  byte_q[$];
    logic   gaps_on     = 1'b1;
    int     stall_left  = 0;
    int     fail_count  = 0;
    int     items_sent  = 0;
    int     bytes_seen  = 0;
    int     cfg_writes  = 0;
    int     edge_hits   = 0;
    int     start_hits  = 0;
    int     cycle_count = 0;

    dir_row_t dir_rows [DIR_N];

    dpcm_delta_encoder uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample_word     (sample_word),
        .pad_sample      (pad_sample),
        .start_of_sample (start_of_sample),
        .byte_valid      (byte_valid),
        .byte_stall      (byte_stall),
        .dpcm_byte       (dpcm_byte)
    );

    always #5 clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Builds a word that reduces to the given level in the current sample mode.
    function automatic word_t word_for_level(input level_t s);
        if (sixteen_bit)
            return {s, 10'($urandom)};
        return {8'($urandom), s, 2'($urandom)};
    endfunction

    // Advances the tracked level and bit packing by one sample.
    task automatic encode_step(input word_t w, input logic pad, input logic start,
                               output logic emitted, output byte_t packed_out);
        level_t s;
        logic   up;
        if (start)
        begin
            track_lvl  = LEVEL_MID;
            pack_bits  = '0;
            pack_count = '0;
            start_hits++;
        end
        if (pad)
            s = LEVEL_MID;
        else if (sixteen_bit)
            s = level_t'(w >> SHIFT_16);
        else
            s = level_t'(w[7:0] >> SHIFT_8);

        if (track_lvl > s)
        begin
            up = 1'b0;
            track_lvl = track_lvl - level_t'(1);
        end
        else if (track_lvl < s)
        begin
            up = 1'b1;
            if (track_lvl != LEVEL_MAX)
                track_lvl = track_lvl + level_t'(1);
            else
                edge_hits++;
        end
        else if (track_lvl == LEVEL_MAX)
        begin
            up = 1'b1;
            edge_hits++;
        end
        else if (track_lvl == LEVEL_MIN)
        begin
            up = 1'b0;
            edge_hits++;
        end
        else
        begin
            up = 1'b1;
            track_lvl = track_lvl + level_t'(1);
        end

        pack_bits  = {up, pack_bits[BYTE_W-1:1]};
        pack_count = pack_count + count_t'(1);
        emitted    = (pack_count == '0);
        packed_out = pack_bits;
        if (emitted)
            pack_bits = '0;
    endtask

    // Drives one sample transfer, optionally after a short gap, and queues its byte.
    task automatic send_sample(input word_t w, input logic pad, input logic start,
                               input logic has_known, input byte_t known_byte);
        int    gap;
        logic  emitted;
        byte_t predicted;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid    <= 1'b1;
        sample_word     <= w;
        pad_sample      <= pad;
        start_of_sample <= start;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        encode_step(w, pad, start, emitted, predicted);
        items_sent++;
        if (emitted)
            byte_q.push_back(has_known ? known_byte : predicted);
    endtask

    // Writes the mode register once the encoder has gone idle.
    task automatic write_config(input logic v);
        @(negedge clk);
        sample_valid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        sixteen_bit = v;
        cfg_writes++;
    endtask

    // Receiver side: random stall bursts while gaps are on.
    always @(negedge clk)
    begin
        if (!gaps_on)
        begin
            byte_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            byte_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            byte_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
        begin
            byte_stall <= 1'b0;
        end
    end

    // Compare each byte transfer with the oldest expected byte.
    always @(posedge clk)
    begin : byte_check
        byte_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (byte_q.size() == 0)
            begin
                $error("dpcm_byte: unexpected transfer, value %02h", dpcm_byte);
                fail_count++;
            end
            else
            begin
                want = byte_q.pop_front();
                bytes_seen++;
                if (dpcm_byte !== want)
                begin
                    $error("dpcm_byte: expected %02h, actual %02h", want, dpcm_byte);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int        seg_len;
        int        target;
        logic      seg_start;
        logic      go_high;
        level_t    held;
        level_t    base;
        seg_kind_t kind;

        // Directed rows: reset level, high byte ignored, start discarding a partial
        // byte, pad overriding the word, and both 16-bit extremes.
        dir_rows = '{
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1, 8'hFF},
            '{ROW_SAMPLE, 16'hFF00, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF03, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF03, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF03, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFF03, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00},
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h00FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_CFG,    16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h03FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'hFC00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h03FF, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00},
            '{ROW_SAMPLE, 16'h0400, 1'b0, 1'b0, 1'b0, 1'b1, 8'h55}
        };

        // Reset once, released away from the rising edge.
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_config(dir_rows[i].cfg_val);
            else
                send_sample(dir_rows[i].word, dir_rows[i].pad, dir_rows[i].start,
                            dir_rows[i].has_known, dir_rows[i].known_byte);
        end

        // Random segments: noise, saturating runs, level tracking and held targets.
        while (items_sent < DIR_N + RAND_ITEMS)
        begin
            if (items_sent >= DIR_N + RAND_ITEMS - QUIET_ITEMS)
                gaps_on = 1'b0;
            else
                gaps_on = ($urandom_range(0, 3) != 0);
            if (gaps_on && $urandom_range(0, 3) == 0)
                write_config(!sixteen_bit);

            kind      = seg_kind_t'($urandom_range(0, 3));
            seg_start = ($urandom_range(0, 1) == 1);
            unique case (kind)
                SEG_NOISE:
                begin
                    seg_len = $urandom_range(8, 24);
                    for (int i = 0; i < seg_len; i++)
                        send_sample(word_t'($urandom), ($urandom_range(0, 7) == 0),
                                    ($urandom_range(0, 15) == 0), 1'b0, 8'h00);
                end
                SEG_SATURATE:
                begin
                    // Long enough to clip at either end from the midpoint and sit on the edge tie.
                    seg_len = $urandom_range(35, 45);
                    go_high = ($urandom_range(0, 1) == 1);
                    for (int i = 0; i < seg_len; i++)
                        send_sample(word_for_level(go_high ? LEVEL_MAX : LEVEL_MIN), 1'b0,
                                    (i == 0) && seg_start, 1'b0, 8'h00);
                end
                SEG_TRACK:
                begin
                    // Samples near the current level, so ties come up often.
                    seg_len = $urandom_range(16, 40);
                    for (int i = 0; i < seg_len; i++)
                    begin
                        base   = ((i == 0) && seg_start) ? LEVEL_MID : track_lvl;
                        target = int'(base) + $urandom_range(0, 2) - 1;
                        if (target < 0)
                            target = 0;
                        if (target > 63)
                            target = 63;
                        send_sample(word_for_level(level_t'(target)),
                                    ($urandom_range(0, 15) == 0),
                                    (i == 0) && seg_start, 1'b0, 8'h00);
                    end
                end
                default:
                begin
                    seg_len = $urandom_range(8, 30);
                    held    = level_t'($urandom_range(0, 63));
                    for (int i = 0; i < seg_len; i++)
                        send_sample(word_for_level(held), 1'b0,
                                    (i == 0) && seg_start, 1'b0, 8'h00);
                end
            endcase
        end

        // Drain the remaining bytes, then allow for the pipeline latency.
        @(negedge clk);
        sample_valid <= 1'b0;
        for (int i = 0; i < 500 && byte_q.size() != 0; i++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (byte_q.size() != 0)
        begin
            $error("dpcm_byte: %0d expected bytes never arrived", byte_q.size());
            fail_count++;
        end

        $display("Run covered %0d samples, %0d bytes checked, %0d mode register writes.",
                 items_sent, bytes_seen, cfg_writes);
        $display("Level hit a clip or edge tie %0d times; start flag seen %0d times.",
                 edge_hits, start_hits);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
